FILE: rtl/core/cst_pkg.sv
`timescale 1ns / 1ps

package cst_pkg;

    // Defaults for the table geometry.
    localparam int SLOTS_DEF    = 8;
    localparam int KEY_BITS_DEF = 16;

    // Fixed field widths of the stream payloads.
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 16;
    localparam int CAP_W    = 4;
    localparam int OCC_W    = 4;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;
    localparam int M_PAD_W  = M_DATA_W - (1 + KEY_W + OCC_W);

    // Operation codes carried in the input tuser.
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SNAPSHOT = 2'd3;

endpackage

FILE: rtl/core/client_slot_set_table.sv
`timescale 1ns / 1ps

// Client slot set table. The block keeps a set of up to SLOTS client keys. Each
// input transaction is one operation selected by tuser: query, add, remove or
// snapshot. Query, add and remove return exactly one result transaction with
// tlast set; add places a new key in the lowest free slot and fails when the
// table is full. Snapshot returns the occupied keys in slot order, at most
// capacity of them, with tlast on the final one; an empty snapshot returns one
// result whose tuser (entry valid) is low. The keys live in a small RAM with a
// registered read, and the slot valid bits and the occupancy count live in
// flip-flops that reset clears, so the table is empty after reset with no
// clearing pass. Every operation scans the RAM one slot at a time, and each
// slot passes an address state, then a compare state, and a finish state then
// issues the result: a hit ends the scan of query, add and remove early, and
// a miss or a snapshot visits all SLOTS slots. Output back-pressure stalls the
// block whenever a result is ready while the output register still holds an
// earlier one: at each snapshot entry after the first and at the final result
// of any operation. A finished result sits in an output register, so the next
// operation is accepted while it waits.
module client_slot_set_table #(
    parameter int SLOTS    = cst_pkg::SLOTS_DEF,
    parameter int KEY_BITS = cst_pkg::KEY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input transactions.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: key [15:0], capacity [19:16], zero [23:20].
    input  logic [cst_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind [1:0].
    input  logic [cst_pkg::KIND_W-1:0]    s_axis_tuser,
    // Result transactions.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: ok [0], entry_key [16:1], occupied [20:17], zero [23:21].
    output logic [cst_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // tuser: entry_valid [0].
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LW = (CW > cst_pkg::CAP_W) ? CW : cst_pkg::CAP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } state_t;

    state_t                        state_reg;
    logic [cst_pkg::KIND_W-1:0]    kind_reg;
    logic [KEY_BITS-1:0]           key_reg;
    logic [cst_pkg::CAP_W-1:0]     cap_reg;
    logic [IW-1:0]                 idx_reg;
    logic [SLOTS-1:0]              valid_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 n_reg;
    logic                          free_found_reg;
    logic [IW-1:0]                 free_idx_reg;
    logic                          res_ok_reg;
    logic                          pend_valid_reg;
    logic [KEY_BITS-1:0]           pend_key_reg;

    logic                          out_valid_reg;
    logic                          out_ok_reg;
    logic [cst_pkg::KEY_W-1:0]     out_key_reg;
    logic                          out_ev_reg;
    logic                          out_last_reg;
    logic [cst_pkg::OCC_W-1:0]     out_occ_reg;

    logic [KEY_BITS-1:0]           rd_data;
    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;

    logic                          slot_valid;
    logic                          hit;
    logic                          last_slot;
    logic                          free_now;
    logic [IW-1:0]                 free_idx_now;
    logic                          is_snap;
    logic                          snap_found;
    logic                          can_push;
    logic                          push_mid;
    logic                          out_push;

    cst_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // The read address is the scan index; in the compare cycle rd_data
    // belongs to that same slot because the index only moves in that cycle.
    always_comb
    begin
        slot_valid   = valid_reg[idx_reg];
        hit          = slot_valid && (rd_data == key_reg);
        last_slot    = (idx_reg == IW'(SLOTS - 1));
        free_now     = free_found_reg || !slot_valid;
        free_idx_now = free_found_reg ? free_idx_reg : idx_reg;
        is_snap      = (kind_reg == cst_pkg::KIND_SNAPSHOT);
        snap_found   = slot_valid && (LW'(n_reg) < LW'(cap_reg));
        can_push     = !out_valid_reg || m_axis_tready;
        push_mid     = is_snap && snap_found && pend_valid_reg;
        // A new result enters the output register in this cycle.
        out_push     = ((state_reg == ST_CHECK) && push_mid && can_push)
                       || ((state_reg == ST_FINISH) && can_push);
        ram_we       = (state_reg == ST_CHECK) && (kind_reg == cst_pkg::KIND_ADD)
                       && !hit && last_slot && free_now;
        ram_waddr    = free_idx_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            free_found_reg <= 1'b0;
            idx_reg        <= '0;
            n_reg          <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && !out_push)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        kind_reg       <= s_axis_tuser;
                        key_reg        <= KEY_BITS'(s_axis_tdata[cst_pkg::KEY_W-1:0]);
                        cap_reg        <= s_axis_tdata[cst_pkg::KEY_W +: cst_pkg::CAP_W];
                        idx_reg        <= '0;
                        n_reg          <= '0;
                        free_found_reg <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        res_ok_reg     <= 1'b0;
                        state_reg      <= ST_READ;
                    end
                end

                ST_READ:
                begin
                    state_reg <= ST_CHECK;
                end

                ST_CHECK:
                begin
                    if (is_snap)
                    begin
                        // Hold in place while an earlier entry cannot leave.
                        if (!(push_mid && !can_push))
                        begin
                            if (push_mid)
                            begin
                                out_valid_reg <= 1'b1;
                                out_ok_reg    <= 1'b1;
                                out_key_reg   <= cst_pkg::KEY_W'(pend_key_reg);
                                out_ev_reg    <= 1'b1;
                                out_last_reg  <= 1'b0;
                                out_occ_reg   <= cst_pkg::OCC_W'(count_reg);
                            end
                            if (snap_found)
                            begin
                                pend_valid_reg <= 1'b1;
                                pend_key_reg   <= rd_data;
                                n_reg          <= n_reg + CW'(1);
                            end
                            res_ok_reg <= 1'b1;
                            if (last_slot)
                            begin
                                state_reg <= ST_FINISH;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + IW'(1);
                                state_reg <= ST_READ;
                            end
                        end
                    end
                    else if (hit)
                    begin
                        res_ok_reg <= 1'b1;
                        if (kind_reg == cst_pkg::KIND_REMOVE)
                        begin
                            valid_reg[idx_reg] <= 1'b0;
                            count_reg          <= count_reg - CW'(1);
                        end
                        state_reg <= ST_FINISH;
                    end
                    else if (last_slot)
                    begin
                        if ((kind_reg == cst_pkg::KIND_ADD) && free_now)
                        begin
                            valid_reg[free_idx_now] <= 1'b1;
                            count_reg               <= count_reg + CW'(1);
                            res_ok_reg              <= 1'b1;
                        end
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        if (!free_found_reg && !slot_valid)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= idx_reg;
                        end
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= ST_READ;
                    end
                end

                ST_FINISH:
                begin
                    if (can_push)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_ok_reg     <= res_ok_reg;
                        out_key_reg    <= pend_valid_reg ? cst_pkg::KEY_W'(pend_key_reg)
                                                         : '0;
                        out_ev_reg     <= pend_valid_reg;
                        out_last_reg   <= 1'b1;
                        out_occ_reg    <= cst_pkg::OCC_W'(count_reg);
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{cst_pkg::M_PAD_W{1'b0}}, out_occ_reg, out_key_reg, out_ok_reg};
    assign m_axis_tuser  = out_ev_reg;
    assign m_axis_tlast  = out_last_reg;

    // The occupancy count always matches the number of set valid bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(valid_reg)))
        else $error("occupancy count differs from valid bits");

    // The count never exceeds the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("occupancy count above table size");

    // A result without an entry is always the final one of its operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("entry-less result without tlast");

    // A pending entry only exists during a snapshot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && (state_reg != ST_IDLE)) |-> is_snap)
        else $error("pending entry outside a snapshot");

    // The key RAM is written only on the final compare of an add.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (state_reg == ST_FINISH) && $past(kind_reg == cst_pkg::KIND_ADD))
        else $error("key RAM written outside an add");

endmodule

FILE: rtl/core/cst_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module cst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: tb/client_slot_set_table_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the client slot set table. Operations go in on the
// input stream, results come back on the output stream, and every result is
// compared with what a small behavioral copy of the table predicts.
module client_slot_set_table_tb;

    localparam int SLOTS          = cst_pkg::SLOTS_DEF;
    localparam int KEY_POOL       = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    // One result transaction, in field order. The packed layout matters where
    // the record is built from the bus; comparisons are done on the whole record.
    typedef struct packed {
        logic                      ok;
        logic [cst_pkg::KEY_W-1:0] entry_key;
        logic                      entry_valid;
        logic                      last;
        logic [cst_pkg::OCC_W-1:0] occupied;
    } table_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // tdata: key [15:0], capacity [19:16], zero [23:20].
    logic [cst_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
    // tuser: kind [1:0].
    logic [cst_pkg::KIND_W-1:0]     s_axis_tuser = cst_pkg::KIND_QUERY;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // tdata: ok [0], entry_key [16:1], occupied [20:17], zero [23:21].
    logic [cst_pkg::M_DATA_W-1:0]   m_axis_tdata;
    // tuser: entry_valid [0].
    logic                           m_axis_tuser;
    logic                           m_axis_tlast;

    // Shadow copy of the table contents.
    logic [cst_pkg::KEY_W-1:0]      shadow_key [SLOTS];
    bit                             shadow_used [SLOTS];
    int unsigned                    shadow_count;

    table_result_t                  pending_results [$];
    logic [cst_pkg::KEY_W-1:0]      key_pool [KEY_POOL];
    int unsigned                    mismatch_count = 0;
    int unsigned                    stall_free_cycles = 0;
    bit                             quiet_stretch = 1'b0;

    client_slot_set_table DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one accepted operation to the shadow table and queues the
    // results that the block must produce for it.
    task automatic predict_table_op(input logic [cst_pkg::KIND_W-1:0] kind,
                                    input logic [cst_pkg::KEY_W-1:0] key,
                                    input logic [cst_pkg::CAP_W-1:0] capacity);
        int            hit;
        int            free_slot;
        int            limit;
        int            emitted;
        bit            have_entry;
        table_result_t res;
        table_result_t held;

        hit = -1;
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (shadow_used[i] && shadow_key[i] == key)
                hit = i;
            if (!shadow_used[i])
                free_slot = i;
        end

        res = '0;
        res.last = 1'b1;
        case (kind)
            cst_pkg::KIND_QUERY:
            begin
                res.ok = (hit >= 0);
            end
            cst_pkg::KIND_ADD:
            begin
                // A key already present counts as a success and changes nothing.
                if (hit >= 0)
                    res.ok = 1'b1;
                else if (free_slot >= 0)
                begin
                    shadow_used[free_slot] = 1'b1;
                    shadow_key[free_slot] = key;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            cst_pkg::KIND_REMOVE:
            begin
                if (hit >= 0)
                begin
                    shadow_used[hit] = 1'b0;
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
            default:
            begin
                // Snapshot: one entry per occupied slot, lowest slot first,
                // capped by the capacity. The final entry carries last.
                limit = (capacity < SLOTS) ? int'(capacity) : SLOTS;
                emitted = 0;
                have_entry = 1'b0;
                held = '0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (shadow_used[i] && emitted < limit)
                    begin
                        if (have_entry)
                            pending_results.push_back(held);
                        held = '0;
                        held.ok = 1'b1;
                        held.entry_key = shadow_key[i];
                        held.entry_valid = 1'b1;
                        held.occupied = shadow_count[cst_pkg::OCC_W-1:0];
                        have_entry = 1'b1;
                        emitted++;
                    end
                end
                if (have_entry)
                begin
                    held.last = 1'b1;
                    pending_results.push_back(held);
                    return;
                end
                // Empty snapshot still answers with one result, no entry.
                res.ok = 1'b1;
            end
        endcase
        res.occupied = shadow_count[cst_pkg::OCC_W-1:0];
        pending_results.push_back(res);
    endtask

    // Drives one operation and returns at the edge where it is accepted.
    // The valid stays high afterwards so back-to-back transactions need no gap.
    task automatic send_op(input logic [cst_pkg::KIND_W-1:0] kind,
                           input logic [cst_pkg::KEY_W-1:0] key,
                           input logic [cst_pkg::CAP_W-1:0] capacity);
        @(negedge clk);
        if (!quiet_stretch && $urandom_range(99) < 12)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {4'b0000, capacity, key};
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        predict_table_op(kind, key, capacity);
    endtask

    // Stops sending and waits for every outstanding result. A stuck block
    // is caught by the watchdog.
    task automatic wait_all_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // An empty table: misses, an empty snapshot and a zero-capacity snapshot.
    task automatic test_empty_table();
        send_op(cst_pkg::KIND_QUERY, 16'h0000, 4'd0);
        send_op(cst_pkg::KIND_REMOVE, 16'hFFFF, 4'd15);
        send_op(cst_pkg::KIND_SNAPSHOT, 16'h1234, 4'd8);
        send_op(cst_pkg::KIND_SNAPSHOT, 16'h0000, 4'd0);
    endtask

    // Fills all slots with extreme keys, then covers duplicates, the full
    // table, capped snapshots and reuse of a freed slot.
    task automatic test_fill_to_full();
        logic [cst_pkg::KEY_W-1:0] fill_keys [SLOTS];

        fill_keys = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                      16'h0001, 16'h8000, 16'h1234, 16'hFEDC};
        foreach (fill_keys[i])
            send_op(cst_pkg::KIND_ADD, fill_keys[i], 4'd0);
        send_op(cst_pkg::KIND_ADD, 16'hFFFF, 4'd7);
        send_op(cst_pkg::KIND_ADD, 16'h4321, 4'd0);
        send_op(cst_pkg::KIND_QUERY, 16'hAAAA, 4'd0);
        send_op(cst_pkg::KIND_SNAPSHOT, 16'h0000, 4'd8);
        send_op(cst_pkg::KIND_SNAPSHOT, 16'hFFFF, 4'd15);
        send_op(cst_pkg::KIND_SNAPSHOT, 16'h0000, 4'd3);
        send_op(cst_pkg::KIND_SNAPSHOT, 16'h0000, 4'd0);
        send_op(cst_pkg::KIND_REMOVE, 16'h5555, 4'd0);
        send_op(cst_pkg::KIND_ADD, 16'h4321, 4'd0);
        send_op(cst_pkg::KIND_SNAPSHOT, 16'h0000, 4'd1);
        send_op(cst_pkg::KIND_REMOVE, 16'h5555, 4'd0);
        send_op(cst_pkg::KIND_QUERY, 16'h4321, 4'd0);
    endtask

    // Random traffic drawn mostly from a small key pool so that hits, full
    // tables and frees happen often. Phases alternate between filling and
    // draining; a stretch in the middle runs with no idling on either side.
    task automatic test_random_traffic(input int n_items);
        logic [cst_pkg::KIND_W-1:0] kind;
        logic [cst_pkg::KEY_W-1:0]  key;
        logic [cst_pkg::CAP_W-1:0]  capacity;
        int unsigned                pick;
        bit                         filling;

        foreach (key_pool[i])
            key_pool[i] = cst_pkg::KEY_W'($urandom_range(16'hFFFF));
        for (int n = 0; n < n_items; n++)
        begin
            quiet_stretch = (n >= n_items / 3) && (n < n_items / 3 + 60);
            filling = ((n / 50) % 2) == 0;
            pick = $urandom_range(99);
            if (filling)
                kind = (pick < 50) ? cst_pkg::KIND_ADD :
                       (pick < 70) ? cst_pkg::KIND_QUERY :
                       (pick < 85) ? cst_pkg::KIND_REMOVE : cst_pkg::KIND_SNAPSHOT;
            else
                kind = (pick < 20) ? cst_pkg::KIND_ADD :
                       (pick < 45) ? cst_pkg::KIND_QUERY :
                       (pick < 85) ? cst_pkg::KIND_REMOVE : cst_pkg::KIND_SNAPSHOT;
            if ($urandom_range(99) < 80)
                key = key_pool[$urandom_range(KEY_POOL - 1)];
            else
                key = cst_pkg::KEY_W'($urandom_range(16'hFFFF));
            capacity = cst_pkg::CAP_W'($urandom_range(15));
            send_op(kind, key, capacity);
        end
        quiet_stretch = 1'b0;
    endtask

    // The sender holds off until the block has delivered everything.
    task automatic test_drain_pause();
        wait_all_results();
        send_op(cst_pkg::KIND_SNAPSHOT, 16'h0000, 4'd15);
    endtask

    // Output side: the sink stalls now and then except in the quiet stretch.
    initial
    begin
        forever
        begin
            @(negedge clk);
            m_axis_tready = quiet_stretch || ($urandom_range(99) >= 12);
        end
    end

    // Result checker: each accepted result must match the oldest expectation.
    always @(posedge clk)
    begin
        table_result_t seen;
        table_result_t want;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = {m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tuser, m_axis_tlast,
                    m_axis_tdata[20:17]};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: ok=%0d key=%h ev=%0d last=%0d occ=%0d",
                             seen.ok, seen.entry_key, seen.entry_valid, seen.last,
                             seen.occupied);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display(
                            "mismatch at %0t: exp ok=%0d key=%h ev=%0d last=%0d occ=%0d",
                            $time, want.ok, want.entry_key, want.entry_valid, want.last,
                            want.occupied);
                        $display(
                            "    got ok=%0d key=%h ev=%0d last=%0d occ=%0d",
                            seen.ok, seen.entry_key, seen.entry_valid, seen.last,
                            seen.occupied);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_free_cycles <= 0;
            else if (stall_free_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[client_slot_set_table] ERROR");
                $finish;
            end
            else
                stall_free_cycles <= stall_free_cycles + 1;
        end
    end

    initial
    begin
        foreach (shadow_used[i])
        begin
            shadow_used[i] = 1'b0;
            shadow_key[i] = '0;
        end
        shadow_count = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_fill_to_full();
        test_random_traffic(230);
        test_drain_pause();
        test_random_traffic(230);

        // Let everything drain, then give the block time to show any stray
        // extra result before the verdict.
        wait_all_results();
        repeat (2 * SLOTS + 12) @(posedge clk);
        if (mismatch_count == 0)
            $display("[client_slot_set_table] OK");
        else
            $display("[client_slot_set_table] ERROR");
        $finish;
    end

endmodule
